@@ src/unary_code_bit_packer_top_macros.svh @@
// Assertion macros shared by the unary code bit packer modules.
`ifndef UNARY_CODE_BIT_PACKER_TOP_MACROS_SVH
`define UNARY_CODE_BIT_PACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define UCBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("unary packer check failed");

// Next-cycle implication, checked out of reset.
`define UCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("unary packer check failed");

`else

`define UCBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define UCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/ucbp_pkg.sv @@
// Package: types and constants of the unary code bit packer.
`timescale 1ns / 1ps

package ucbp_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;

    localparam logic       KIND_ENCODE = 1'b0;
    localparam logic       KIND_END    = 1'b1;
    localparam logic [7:0] BYTE_ONES   = 8'hff;
    localparam logic [3:0] BYTE_BITS_FULL = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PACK,
        ST_END,
        ST_ERR
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;     // word accepted on the input channel
        logic step;      // pack one chunk of the current code
        logic end_emit;  // emit the end-of-stream word and close the stream
        logic err_emit;  // emit the error word
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic item_end;   // input word is an end item
        logic fail_now;   // input encode word fails (capacity or earlier failure)
        logic pack_done;  // this packing step completes the code
    } status_t;

endpackage

@@ src/ucbp_ctrl.sv @@
// Controller state machine of the unary code bit packer.
`timescale 1ns / 1ps
`include "unary_code_bit_packer_top_macros.svh"

module ucbp_ctrl
    import ucbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.item_end)
                        state_next = ST_END;
                    else if (st.fail_now)
                        state_next = ST_ERR;
                    else
                        state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (st.out_free && st.pack_done)
                    state_next = ST_IDLE;
            end
            ST_END, ST_ERR:
            begin
                if (st.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ST_PACK: cmd.step     = st.out_free;
            ST_END:  cmd.end_emit = st.out_free;
            ST_ERR:  cmd.err_emit = st.out_free;
            default: in_stall = 1'b1;
        endcase
    end

    `UCBP_ASSERT_NEXT(a_end_goes_end, clk, rst_n, cmd.start && st.item_end, state_reg == ST_END)

endmodule

@@ src/ucbp_datapath.sv @@
// Datapath of the unary code bit packer: stream state, packing step, output register.
`timescale 1ns / 1ps
`include "unary_code_bit_packer_top_macros.svh"

module ucbp_datapath
    import ucbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              st,
    input  logic                 kind,
    input  logic [7:0]           value,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic [3:0]           byte_bits,
    output logic [18:0]          total_bits,
    output logic                 error,
    output logic                 last
);

    logic [2:0]  offset_reg;
    logic [15:0] cap_reg;

    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  fill_reg, fill_next;
    logic [18:0] bits_reg, bits_next;
    logic [15:0] bytes_reg, bytes_next;
    logic        open_reg, open_next;
    logic        failed_reg, failed_next;
    logic [7:0]  ones_reg, ones_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [3:0]  out_bits_reg, out_bits_next;
    logic [18:0] out_total_reg, out_total_next;
    logic        out_err_reg, out_err_next;
    logic        out_last_reg, out_last_next;

    logic [2:0]  eff_fill;
    logic [15:0] eff_bytes;
    logic [18:0] eff_bits;
    logic [7:0]  eff_partial;
    logic        eff_failed;
    logic [18:0] used;
    logic [19:0] need;
    logic        over;

    logic [3:0]  space;
    logic        chunk_full;
    logic [7:0]  ones_left;
    logic [7:0]  part_ones;
    logic [3:0]  new_fill;
    logic        out_free;
    logic        emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 3'd0;
            cap_reg    <= 16'd128;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_OFFSET: offset_reg <= cfg_data[2:0];
                CFG_CAPACITY:     cap_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Values that an encode word sees: the open stream's state, or a fresh one at the start offset
    always_comb
    begin
        eff_fill    = open_reg ? fill_reg    : offset_reg;
        eff_bytes   = open_reg ? bytes_reg   : 16'd0;
        eff_bits    = open_reg ? bits_reg    : 19'd0;
        eff_partial = open_reg ? partial_reg : 8'd0;
        eff_failed  = open_reg && failed_reg;
        used        = {eff_bytes, 3'b000} + 19'(eff_fill);
        need        = 20'(used) + 20'(value) + 20'd1;
        over        = need > {1'b0, cap_reg, 3'b000};
    end

    // One packing step: fill the current byte with ones, or finish the code
    always_comb
    begin
        space      = BYTE_BITS_FULL - 4'(fill_reg);
        chunk_full = ones_reg >= 8'(space);
        ones_left  = ones_reg - 8'(space);
        part_ones  = ~(BYTE_ONES << ones_reg[2:0]);
        new_fill   = 4'(fill_reg) + 4'(ones_reg[2:0]) + 4'd1;
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        st.out_free  = out_free;
        st.item_end  = (kind == KIND_END);
        st.fail_now  = eff_failed || over;
        st.pack_done = !chunk_full;
    end

    always_comb
    begin
        partial_next   = partial_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        bytes_next     = bytes_reg;
        open_next      = open_reg;
        failed_next    = failed_reg;
        ones_next      = ones_reg;
        emit           = 1'b0;
        out_byte_next  = out_byte_reg;
        out_bits_next  = out_bits_reg;
        out_total_next = out_total_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;

        if (cmd.start && kind == KIND_ENCODE)
        begin
            open_next    = 1'b1;
            fill_next    = eff_fill;
            bytes_next   = eff_bytes;
            partial_next = eff_partial;
            bits_next    = eff_bits;
            failed_next  = eff_failed;
            if (eff_failed || over)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                bits_next = eff_bits + 19'(value) + 19'd1;
                ones_next = value;
            end
        end

        if (cmd.step)
        begin
            if (chunk_full)
            begin
                // top of the byte is all ones: emit it and carry on at bit 0
                emit          = 1'b1;
                out_byte_next = partial_reg | (BYTE_ONES << fill_reg);
                out_bits_next = BYTE_BITS_FULL;
                out_last_next = ones_left < 8'd7;
                ones_next     = ones_left;
                partial_next  = 8'd0;
                fill_next     = 3'd0;
                bytes_next    = bytes_reg + 16'd1;
            end
            else
            begin
                // remaining ones and the closing zero fit in this byte
                ones_next = 8'd0;
                if (new_fill == BYTE_BITS_FULL)
                begin
                    emit          = 1'b1;
                    out_byte_next = partial_reg | (part_ones << fill_reg);
                    out_bits_next = BYTE_BITS_FULL;
                    out_last_next = 1'b1;
                    partial_next  = 8'd0;
                    fill_next     = 3'd0;
                    bytes_next    = bytes_reg + 16'd1;
                end
                else
                begin
                    partial_next = partial_reg | (part_ones << fill_reg);
                    fill_next    = new_fill[2:0];
                end
            end
            out_total_next = bits_reg;
            out_err_next   = 1'b0;
        end

        if (cmd.err_emit)
        begin
            emit           = 1'b1;
            out_byte_next  = 8'd0;
            out_bits_next  = 4'd0;
            out_total_next = bits_reg;
            out_err_next   = 1'b1;
            out_last_next  = 1'b1;
        end

        if (cmd.end_emit)
        begin
            emit           = 1'b1;
            out_byte_next  = 8'd0;
            out_bits_next  = 4'd0;
            out_total_next = open_reg ? bits_reg : 19'd0;
            out_err_next   = open_reg && failed_reg;
            out_last_next  = 1'b1;
            if (open_reg && !failed_reg && fill_reg != 3'd0)
            begin
                out_byte_next = partial_reg;
                out_bits_next = 4'(fill_reg);
            end
            // close the stream
            partial_next = 8'd0;
            fill_next    = 3'd0;
            bits_next    = 19'd0;
            bytes_next   = 16'd0;
            open_next    = 1'b0;
            failed_next  = 1'b0;
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= 8'd0;
            fill_reg      <= 3'd0;
            bits_reg      <= 19'd0;
            bytes_reg     <= 16'd0;
            open_reg      <= 1'b0;
            failed_reg    <= 1'b0;
            ones_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            bytes_reg     <= bytes_next;
            open_reg      <= open_next;
            failed_reg    <= failed_next;
            ones_reg      <= ones_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_bits_reg  <= out_bits_next;
        out_total_reg <= out_total_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_bits  = out_bits_reg;
    assign total_bits = out_total_reg;
    assign error      = out_err_reg;
    assign last       = out_last_reg;

    `UCBP_ASSERT_IMPLY(a_emit_when_free, clk, rst_n, emit, out_free)
    `UCBP_ASSERT_IMPLY(a_failed_is_open, clk, rst_n, failed_reg, open_reg)
    `UCBP_ASSERT_IMPLY(a_error_is_last, clk, rst_n, out_valid_reg && out_err_reg, out_last_reg)

endmodule

@@ src/unary_code_bit_packer_top.sv @@
// Top level of the unary code bit packer: controller and datapath.
`timescale 1ns / 1ps
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    kind, value
//  output    out        out_valid / out_stall  out_byte, byte_bits, total_bits, error, last
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  An encode word of value v is accepted, then packed in v/8 + 2 packing steps at most,
//  one step a cycle, at most one output byte a step; value 255 at offset 7 gives 32 bytes
//  in 33 steps. End and error words are accepted, then emitted as a single output word.
//  The packing step logic in the datapath sets the step count; a stalled output holds
//  the step until the output register frees.
//  Reset (rst_n low, asynchronous) closes the stream, empties the output register,
//  sets the start offset to 0 and the capacity to 128 bytes.
//  Configuration writes are always taken (cfg_ready held high).
//
module unary_code_bit_packer_top
    import ucbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [7:0]           value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic [3:0]           byte_bits,
    output logic [18:0]          total_bits,
    output logic                 error,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    cmd_t    cmd;
    status_t st;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    // Sequence words: accept, then emit the bytes one step at a time
    ucbp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Hold the stream state, pack the bits and drive the output word
    ucbp_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .kind       (kind),
        .value      (value),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_bits  (byte_bits),
        .total_bits (total_bits),
        .error      (error),
        .last       (last)
    );

endmodule
